// ===== hdl/vna_pkg.sv =====
`default_nettype none
package vna_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 1024;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned NORM_W    = 16;
  localparam int unsigned EDGE_W    = COORD_W + 1;
  localparam int unsigned CROSS_W   = 2 * EDGE_W + 1;
  localparam int unsigned MUL_W     = 32;
  localparam int unsigned PROD_W    = 2 * MUL_W;
  localparam int unsigned MAG_W     = ACC_W;
  localparam int unsigned SQ_W      = 64;
  localparam int unsigned ROOT_W    = 32;
  localparam int unsigned QUO_W     = 16;
  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned LARGE_BIT = 31;
  // normalized magnitudes keep their top bit here (30 significant bits)
  localparam int unsigned NORM_MSB  = 29;
  localparam int unsigned SQRT_STEPS = SQ_W / 2;
  localparam int unsigned DIV_STEPS  = QUO_W;
  localparam logic [NORM_W-1:0] NORM_ONE = NORM_W'(16384);

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD = 2'd0,
    REQ_TRI  = 2'd1,
    REQ_READ = 2'd2
  } req_type_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_DEGEN    = 2'd1,
    ST_UNLOADED = 2'd2
  } status_e;

  typedef enum logic {
    IOP_SQRT,
    IOP_DIV
  } iter_op_e;

  typedef struct packed {
    logic     start;
    iter_op_e op;
  } iter_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_stat_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_TRA,
    S_TRB,
    S_TRC,
    S_TRD,
    S_CROSS,
    S_ACC_RD,
    S_ACC_WR,
    S_RD_ADDR,
    S_RD_DATA,
    S_SQ1,
    S_NORM,
    S_SQ2,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_RESULT
  } state_e;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0]   acc,
    input logic signed [CROSS_W-1:0] n
  );
    logic signed [ACC_W+1:0] s;
    logic signed [ACC_W+1:0] hi;
    logic signed [ACC_W+1:0] lo;
    s  = (ACC_W+2)'(acc) + (ACC_W+2)'(n);
    hi = {3'b000, {(ACC_W-1){1'b1}}};
    lo = {3'b111, {(ACC_W-1){1'b0}}};
    if (s > hi) return hi[ACC_W-1:0];
    if (s < lo) return lo[ACC_W-1:0];
    return s[ACC_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/vna_if.sv =====
`default_nettype none
interface vna_req_if;
  import vna_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [REQ_W-1:0]          req_type;
  logic [IDX_W-1:0]          vertex_id;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic [IDX_W-1:0]          corner_a;
  logic [IDX_W-1:0]          corner_b;
  logic [IDX_W-1:0]          corner_c;

  modport source (output valid, req_type, vertex_id, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, input ready);
  modport sink (input valid, req_type, vertex_id, pos_x, pos_y, pos_z,
                corner_a, corner_b, corner_c, output ready);
endinterface

interface vna_rsp_if;
  import vna_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         out_vertex;
  logic signed [NORM_W-1:0] norm_x;
  logic signed [NORM_W-1:0] norm_y;
  logic signed [NORM_W-1:0] norm_z;
  logic [STAT_W-1:0]        status;

  modport source (output valid, out_vertex, norm_x, norm_y, norm_z, status,
                  input ready);
  modport sink (input valid, out_vertex, norm_x, norm_y, norm_z, status,
                output ready);
endinterface
`default_nettype wire

// ===== hdl/vertex_normal_accumulator_core.sv =====
`default_nettype none
// Vertex normal accumulator.
// req_i takes one word per request: load a vertex position (clears its
// accumulator), add a triangle's edge cross product to its three corners
// (saturating), or read a vertex normal. Only a read returns a word on
// rsp_o: the unit normal in Q1.14 with status ok, degenerate (0,1,0) or
// not loaded. cfg_we_i/cfg_wdata_i write the squared-length threshold.
// req_i.ready is high only while the sequencer idles; one request is
// worked at a time.
// A triangle takes three position reads, six products through the shared
// multiplier and three accumulator read-modify-writes; a full read runs up
// to 29 normalize shifts, a 32-step square root and three 16-step divides
// on the shared iteration unit.
// After reset the valid store is swept clear with ready low;
// configuration writes are taken meanwhile.
// rsp_o holds a finished word in an output register; while the receiver
// stalls the block still takes new requests, and only the next read waits
// for that register to drain.
module vertex_normal_accumulator_core #(
  parameter int unsigned MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [vna_pkg::CFG_W-1:0] cfg_wdata_i,
  vna_req_if.sink                        req_i,
  vna_rsp_if.source                      rsp_o
);
  import vna_pkg::*;

  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned PW = 3 * COORD_W;
  localparam int unsigned XW = 3 * ACC_W;

  function automatic logic in_range(input logic [IDX_W-1:0] v);
    return 32'(v) < MAX_VERTICES;
  endfunction

  state_e state_q, state_d;

  logic [CFG_W-1:0]  min_q;
  logic [AW-1:0]     clr_q;
  logic [2:0]        mstep_q;
  logic [1:0]        sel_q;
  logic [1:0]        comp_q;

  // latched request
  logic [IDX_W-1:0]  idx_q;
  logic [PW-1:0]     ppos_q;
  logic [IDX_W-1:0]  ca_q, cb_q, cc_q;

  // triangle working set
  logic              va_q, vb_q;
  logic [PW-1:0]     pa_q, pb_q;
  logic signed [EDGE_W-1:0]  e1_q [3];
  logic signed [EDGE_W-1:0]  e2_q [3];
  logic signed [CROSS_W-1:0] cross_q [3];
  logic signed [PROD_W-1:0]  psum_q;

  // read working set
  logic              sign_q [3];
  logic [MAG_W-1:0]  mag_q [3];
  logic [SQ_W-1:0]   len_q;
  logic [ROOT_W-1:0] r_q;
  logic [NORM_W-1:0] norm_q [3];
  status_e           stat_q;

  // output register
  logic              out_valid_q;
  logic [IDX_W-1:0]  out_vtx_q;
  logic [NORM_W-1:0] out_norm_q [3];
  status_e           out_stat_q;

  // memories
  logic              val_we, val_wdata, val_rdata;
  logic [AW-1:0]     val_waddr, rd_addr;
  logic              pos_we;
  logic [PW-1:0]     pos_rdata;
  logic              acc_we;
  logic [AW-1:0]     acc_waddr, acc_raddr;
  logic [XW-1:0]     acc_wdata, acc_rdata;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  iter_cmd_t         icmd;
  iter_stat_t        istat;
  logic [SQ_W-1:0]   iopnd;
  logic [ROOT_W-1:0] ires;

  logic              req_fire, out_free, tri_ok, big_mag, hi_any, lo_all;
  logic              norm_done, clr_last, degen;
  logic [IDX_W-1:0]  corner;
  logic [MAG_W-1:0]  rd_mag [3];
  logic [MAG_W-1:0]  mag_sel;
  logic [SQ_W-1:0]   len_sum;
  logic [2:0]        pj;
  logic [QUO_W-1:0]  q_cl;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign clr_last    = (clr_q == AW'(MAX_VERTICES - 1));
  assign pj          = mstep_q - 3'd1;

  always_comb begin
    unique case (sel_q)
      2'd0:    corner = ca_q;
      2'd1:    corner = cb_q;
      default: corner = cc_q;
    endcase
    unique case (comp_q)
      2'd0:    mag_sel = mag_q[0];
      2'd1:    mag_sel = mag_q[1];
      default: mag_sel = mag_q[2];
    endcase
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [ACC_W-1:0] a;
      a = acc_rdata[k*ACC_W +: ACC_W];
      rd_mag[k] = a[ACC_W-1] ? MAG_W'(-a) : MAG_W'(a);
    end
    big_mag = |{rd_mag[0][MAG_W-1:LARGE_BIT], rd_mag[1][MAG_W-1:LARGE_BIT],
                rd_mag[2][MAG_W-1:LARGE_BIT]};
    hi_any = |{mag_q[0][MAG_W-1:NORM_MSB+1], mag_q[1][MAG_W-1:NORM_MSB+1],
               mag_q[2][MAG_W-1:NORM_MSB+1]};
    lo_all = ~|{mag_q[0][MAG_W-1:NORM_MSB], mag_q[1][MAG_W-1:NORM_MSB],
                mag_q[2][MAG_W-1:NORM_MSB]};
    norm_done = !hi_any && !lo_all;
    tri_ok = va_q && vb_q && val_rdata && in_range(ca_q) && in_range(cb_q)
             && in_range(cc_q);
    len_sum = (mstep_q == 3'd1) ? SQ_W'(mul_p) : len_q + SQ_W'(mul_p);
    degen   = (len_sum <= SQ_W'(min_q));
    q_cl    = (ires[QUO_W-1:0] > NORM_ONE) ? NORM_ONE : ires[QUO_W-1:0];
  end

  // multiplier operands: cross product terms or component squares
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_CROSS) begin
      unique case (mstep_q)
        3'd0: begin mul_a = MUL_W'(e1_q[1]); mul_b = MUL_W'(e2_q[2]); end
        3'd1: begin mul_a = MUL_W'(e1_q[2]); mul_b = MUL_W'(e2_q[1]); end
        3'd2: begin mul_a = MUL_W'(e1_q[2]); mul_b = MUL_W'(e2_q[0]); end
        3'd3: begin mul_a = MUL_W'(e1_q[0]); mul_b = MUL_W'(e2_q[2]); end
        3'd4: begin mul_a = MUL_W'(e1_q[0]); mul_b = MUL_W'(e2_q[1]); end
        3'd5: begin mul_a = MUL_W'(e1_q[1]); mul_b = MUL_W'(e2_q[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else begin
      unique case (mstep_q)
        3'd0: begin mul_a = MUL_W'(mag_q[0]); mul_b = MUL_W'(mag_q[0]); end
        3'd1: begin mul_a = MUL_W'(mag_q[1]); mul_b = MUL_W'(mag_q[1]); end
        3'd2: begin mul_a = MUL_W'(mag_q[2]); mul_b = MUL_W'(mag_q[2]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  // memory ports
  always_comb begin
    unique case (state_q)
      S_TRA:   rd_addr = AW'(ca_q);
      S_TRB:   rd_addr = AW'(cb_q);
      S_TRC:   rd_addr = AW'(cc_q);
      default: rd_addr = AW'(idx_q);
    endcase
    acc_raddr = (state_q == S_ACC_RD) ? AW'(corner) : AW'(idx_q);
    val_we    = (state_q == S_CLEAR) || (state_q == S_LOAD && in_range(idx_q));
    val_waddr = (state_q == S_CLEAR) ? clr_q : AW'(idx_q);
    val_wdata = (state_q == S_LOAD);
    pos_we    = (state_q == S_LOAD) && in_range(idx_q);
    acc_we    = pos_we || (state_q == S_ACC_WR);
    acc_waddr = (state_q == S_ACC_WR) ? AW'(corner) : AW'(idx_q);
    acc_wdata = '0;
    if (state_q == S_ACC_WR) begin
      for (int k = 0; k < 3; k++) begin
        acc_wdata[k*ACC_W +: ACC_W] = sat_add(acc_rdata[k*ACC_W +: ACC_W], cross_q[k]);
      end
    end
  end

  // iteration unit command
  always_comb begin
    icmd.start = (state_q == S_SQRT_GO) || (state_q == S_DIV_GO);
    icmd.op    = (state_q == S_DIV_GO) ? IOP_DIV : IOP_SQRT;
    iopnd      = (state_q == S_DIV_GO)
               ? (SQ_W'(mag_sel) << FRAC_BITS) + SQ_W'(r_q >> 1) : len_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_last) state_d = S_IDLE;
      S_IDLE: begin
        if (req_i.valid) begin
          unique case (req_type_e'(req_i.req_type))
            REQ_LOAD: state_d = S_LOAD;
            REQ_TRI:  state_d = S_TRA;
            REQ_READ: state_d = S_RD_ADDR;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_LOAD:    state_d = S_IDLE;
      S_TRA:     state_d = S_TRB;
      S_TRB:     state_d = S_TRC;
      S_TRC:     state_d = S_TRD;
      S_TRD:     state_d = tri_ok ? S_CROSS : S_IDLE;
      S_CROSS:   if (mstep_q == 3'd6) state_d = S_ACC_RD;
      S_ACC_RD:  state_d = S_ACC_WR;
      S_ACC_WR:  state_d = (sel_q == 2'd2) ? S_IDLE : S_ACC_RD;
      S_RD_ADDR: state_d = in_range(idx_q) ? S_RD_DATA : S_RESULT;
      S_RD_DATA: begin
        priority if (!val_rdata) state_d = S_RESULT;
        else if (big_mag)        state_d = S_NORM;
        else                     state_d = S_SQ1;
      end
      S_SQ1:     if (mstep_q == 3'd3) state_d = degen ? S_RESULT : S_NORM;
      S_NORM:    if (norm_done) state_d = S_SQ2;
      S_SQ2:     if (mstep_q == 3'd3) state_d = S_SQRT_GO;
      S_SQRT_GO: state_d = S_SQRT_WAIT;
      S_SQRT_WAIT: if (istat.done) state_d = S_DIV_GO;
      S_DIV_GO:  state_d = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (istat.done) state_d = (comp_q == 2'd2) ? S_RESULT : S_DIV_GO;
      end
      S_RESULT:  if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      min_q       <= '0;
      clr_q       <= '0;
      mstep_q     <= '0;
      sel_q       <= '0;
      comp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) min_q <= cfg_wdata_i;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if ((state_q == S_CROSS || state_q == S_SQ1 || state_q == S_SQ2)
          && state_d == state_q) begin
        mstep_q <= mstep_q + 3'd1;
      end else begin
        mstep_q <= '0;
      end
      if (state_q == S_IDLE)   sel_q <= '0;
      if (state_q == S_ACC_WR) sel_q <= sel_q + 2'd1;
      if (state_q == S_SQRT_WAIT) comp_q <= '0;
      if (state_q == S_DIV_WAIT && istat.done) comp_q <= comp_q + 2'd1;
      if (state_q == S_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      idx_q  <= req_i.vertex_id;
      ppos_q <= {req_i.pos_z[COORD_W-1:0], req_i.pos_y[COORD_W-1:0],
                 req_i.pos_x[COORD_W-1:0]};
      ca_q   <= req_i.corner_a;
      cb_q   <= req_i.corner_b;
      cc_q   <= req_i.corner_c;
    end
    unique case (state_q)
      S_TRB: begin
        va_q <= val_rdata;
        pa_q <= pos_rdata;
      end
      S_TRC: begin
        vb_q <= val_rdata;
        pb_q <= pos_rdata;
      end
      S_TRD: begin
        for (int k = 0; k < 3; k++) begin
          e1_q[k] <= EDGE_W'(signed'(pb_q[k*COORD_W +: COORD_W]))
                   - EDGE_W'(signed'(pa_q[k*COORD_W +: COORD_W]));
          e2_q[k] <= EDGE_W'(signed'(pos_rdata[k*COORD_W +: COORD_W]))
                   - EDGE_W'(signed'(pa_q[k*COORD_W +: COORD_W]));
        end
      end
      S_CROSS: begin
        if (mstep_q != 3'd0) begin
          if (!pj[0]) psum_q <= mul_p;
          else cross_q[pj[2:1]] <= CROSS_W'(psum_q - mul_p);
        end
      end
      S_RD_ADDR: begin
        stat_q <= ST_UNLOADED;
        for (int k = 0; k < 3; k++) norm_q[k] <= '0;
      end
      S_RD_DATA: begin
        stat_q <= val_rdata ? ST_OK : ST_UNLOADED;
        for (int k = 0; k < 3; k++) begin
          sign_q[k] <= acc_rdata[k*ACC_W + ACC_W - 1];
          mag_q[k]  <= rd_mag[k];
        end
      end
      S_SQ1: begin
        if (mstep_q != 3'd0) len_q <= len_sum;
        if (mstep_q == 3'd3 && degen) begin
          stat_q    <= ST_DEGEN;
          norm_q[0] <= '0;
          norm_q[1] <= NORM_ONE;
          norm_q[2] <= '0;
        end
      end
      S_NORM: begin
        for (int k = 0; k < 3; k++) begin
          priority if (hi_any) mag_q[k] <= mag_q[k] >> 1;
          else if (lo_all)     mag_q[k] <= mag_q[k] << 1;
          else                 mag_q[k] <= mag_q[k];
        end
      end
      S_SQ2: begin
        if (mstep_q != 3'd0) len_q <= len_sum;
      end
      S_SQRT_WAIT: begin
        if (istat.done) r_q <= (ires == '0) ? ROOT_W'(1) : ires;
      end
      S_DIV_WAIT: begin
        if (istat.done) begin
          norm_q[comp_q] <= sign_q[comp_q] ? NORM_W'(-q_cl) : NORM_W'(q_cl);
        end
      end
      default: begin
      end
    endcase
    if (state_q == S_RESULT && out_free) begin
      out_vtx_q  <= idx_q;
      out_stat_q <= stat_q;
      for (int k = 0; k < 3; k++) out_norm_q[k] <= norm_q[k];
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.out_vertex = out_vtx_q;
  assign rsp_o.norm_x     = out_norm_q[0];
  assign rsp_o.norm_y     = out_norm_q[1];
  assign rsp_o.norm_z     = out_norm_q[2];
  assign rsp_o.status     = out_stat_q;

  vna_ram #(.W(1), .DEPTH(MAX_VERTICES)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .raddr_i (rd_addr),
    .rdata_o (val_rdata)
  );

  vna_ram #(.W(PW), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (AW'(idx_q)),
    .wdata_i (ppos_q),
    .raddr_i (rd_addr),
    .rdata_o (pos_rdata)
  );

  vna_ram #(.W(XW), .DEPTH(MAX_VERTICES)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  vna_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  vna_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (icmd),
    .opnd_i (iopnd),
    .dvsr_i (r_q),
    .stat_o (istat),
    .res_o  (ires)
  );

  // the iteration unit is only started when it has finished the last job
  a_iter_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    icmd.start |-> !istat.busy)
    else $error("iteration unit started while busy");

  // every accumulator write-back follows its own read
  a_rmw_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ACC_WR |-> $past(state_q) == S_ACC_RD)
    else $error("accumulator write without preceding read");

  a_unloaded_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stat_q == ST_UNLOADED
      |-> out_norm_q[0] == '0 && out_norm_q[1] == '0 && out_norm_q[2] == '0)
    else $error("unloaded vertex returned a nonzero normal");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stat_q == ST_OK
      |-> $signed(out_norm_q[1]) <= $signed(NORM_ONE)
       && $signed(out_norm_q[1]) >= -$signed(NORM_ONE))
    else $error("normal component outside unit range");
endmodule
`default_nettype wire

// ===== hdl/vna_ram.sv =====
`default_nettype none
module vna_ram #(
  parameter  int unsigned W     = 8,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic [W-1:0]       rdata_o
);
  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// ===== hdl/vna_mul.sv =====
`default_nettype none
module vna_mul (
  input  wire logic                clk_i,
  input  wire logic signed [vna_pkg::MUL_W-1:0] a_i,
  input  wire logic signed [vna_pkg::MUL_W-1:0] b_i,
  output logic signed [vna_pkg::PROD_W-1:0]     p_o
);
  import vna_pkg::*;
  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;
endmodule
`default_nettype wire

// ===== hdl/vna_iter.sv =====
`default_nettype none
module vna_iter (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire vna_pkg::iter_cmd_t          cmd_i,
  input  wire logic [vna_pkg::SQ_W-1:0]    opnd_i,
  input  wire logic [vna_pkg::ROOT_W-1:0]  dvsr_i,
  output vna_pkg::iter_stat_t              stat_o,
  output logic [vna_pkg::ROOT_W-1:0]       res_o
);
  import vna_pkg::*;
  localparam int unsigned CNT_W = $clog2(SQRT_STEPS);

  iter_op_e         op_q;
  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SQ_W-1:0]  a_q;
  logic [SQ_W-1:0]  b_q;
  logic [SQ_W-1:0]  c_q;
  logic [SQ_W-1:0]  x;
  logic [SQ_W-1:0]  y;
  logic [SQ_W-1:0]  diff;
  logic             borrow;
  logic             ge;
  logic             last;

  // one shared compare-subtract: root digit test or restoring divide step
  always_comb begin
    x = (op_q == IOP_SQRT) ? a_q : {a_q[SQ_W-2:0], b_q[SQ_W-1]};
    y = (op_q == IOP_SQRT) ? b_q + c_q : c_q;
    {borrow, diff} = {1'b0, x} - {1'b0, y};
    ge   = !borrow;
    last = (op_q == IOP_SQRT) ? (cnt_q == CNT_W'(SQRT_STEPS - 1))
                              : (cnt_q == CNT_W'(DIV_STEPS - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= IOP_SQRT;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        op_q   <= cmd_i.op;
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      if (cmd_i.op == IOP_SQRT) begin
        a_q <= opnd_i;
        b_q <= '0;
        c_q <= {2'b01, {(SQ_W-2){1'b0}}};
      end else begin
        a_q <= opnd_i >> QUO_W;
        b_q <= {opnd_i[QUO_W-1:0], {(SQ_W-QUO_W){1'b0}}};
        c_q <= SQ_W'(dvsr_i);
      end
    end else if (busy_q) begin
      if (op_q == IOP_SQRT) begin
        if (ge) begin
          a_q <= diff;
          b_q <= (b_q >> 1) + c_q;
        end else begin
          b_q <= b_q >> 1;
        end
        c_q <= c_q >> 2;
      end else begin
        a_q <= ge ? diff : x;
        b_q <= {b_q[SQ_W-2:0], ge};
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign res_o       = b_q[ROOT_W-1:0];
endmodule
`default_nettype wire

// ===== verif/vna_normal_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vna_normal_checker (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [vna_pkg::CFG_W-1:0] cfg_wdata_i,
  vna_req_if                             req,
  vna_rsp_if                             rsp,
  output int unsigned                    fail_count_o,
  output int unsigned                    normals_due_o,
  output int unsigned                    normals_checked_o
);
  import vna_pkg::*;

  typedef struct {
    logic [IDX_W-1:0]         vtx;
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
    status_e                  st;
  } normal_t;

  localparam longint ACC_HI = (64'sd1 <<< (ACC_W - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;

  logic signed [COORD_W-1:0] pos_mem [MAX_VERTICES_DEF][3];
  longint                    acc_mem [MAX_VERTICES_DEF][3];
  bit                        loaded  [MAX_VERTICES_DEF];
  logic [CFG_W-1:0]          min_len_sq;
  normal_t                   normal_q [$];

  assign normals_due_o = normal_q.size();

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count_o++;
  endtask

  function automatic longint clamp_add(input longint a, input longint n);
    longint s;
    s = a + n;
    if (s > ACC_HI) return ACC_HI;
    if (s < ACC_LO) return ACC_LO;
    return s;
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Unit normal of one vertex, from magnitudes scaled so the largest has 30 bits.
  function automatic normal_t vertex_normal(input logic [IDX_W-1:0] v);
    normal_t     o;
    logic [63:0] mag [3];
    logic [63:0] big, len_sq, r, q;
    bit          huge;
    int          bl;
    o.vtx = v; o.nx = 0; o.ny = 0; o.nz = 0; o.st = ST_OK;
    big = 0; len_sq = 0; huge = 0; bl = 0;
    if (!loaded[v]) begin
      o.st = ST_UNLOADED;
      return o;
    end
    for (int k = 0; k < 3; k++) begin
      mag[k] = acc_mem[v][k] < 0 ? 64'(-acc_mem[v][k]) : 64'(acc_mem[v][k]);
      if (mag[k] >= (64'd1 << LARGE_BIT)) huge = 1;
      if (mag[k] > big) big = mag[k];
    end
    if (!huge) begin
      for (int k = 0; k < 3; k++) len_sq += mag[k] * mag[k];
      if (len_sq <= 64'(min_len_sq)) begin
        o.ny = NORM_ONE;
        o.st = ST_DEGEN;
        return o;
      end
    end
    while (big != 0) begin
      bl++;
      big >>= 1;
    end
    len_sq = 0;
    for (int k = 0; k < 3; k++) begin
      if (bl > 30) mag[k] >>= (bl - 30);
      else mag[k] <<= (30 - bl);
      len_sq += mag[k] * mag[k];
    end
    r = root_floor(len_sq);
    if (r == 0) r = 1;
    for (int k = 0; k < 3; k++) begin
      q = ((mag[k] << FRAC_BITS) + (r >> 1)) / r;
      if (q > 16384) q = 16384;
      if (acc_mem[v][k] < 0) q = -q;
      case (k)
        0: o.nx = q[NORM_W-1:0];
        1: o.ny = q[NORM_W-1:0];
        default: o.nz = q[NORM_W-1:0];
      endcase
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (loaded[i]) loaded[i] = 0;
      min_len_sq = 0;
    end else begin
      if (cfg_we_i) min_len_sq = cfg_wdata_i;
      if (req.valid && req.ready) begin
        case (req.req_type)
          REQ_LOAD: begin
            pos_mem[req.vertex_id][0] = req.pos_x;
            pos_mem[req.vertex_id][1] = req.pos_y;
            pos_mem[req.vertex_id][2] = req.pos_z;
            for (int k = 0; k < 3; k++) acc_mem[req.vertex_id][k] = 0;
            loaded[req.vertex_id] = 1;
          end
          REQ_TRI: begin
            automatic logic [IDX_W-1:0] ca = req.corner_a;
            automatic logic [IDX_W-1:0] cb = req.corner_b;
            automatic logic [IDX_W-1:0] cc = req.corner_c;
            automatic longint e1 [3];
            automatic longint e2 [3];
            automatic longint n [3];
            if (loaded[ca] && loaded[cb] && loaded[cc]) begin
              for (int k = 0; k < 3; k++) begin
                e1[k] = longint'(pos_mem[cb][k]) - longint'(pos_mem[ca][k]);
                e2[k] = longint'(pos_mem[cc][k]) - longint'(pos_mem[ca][k]);
              end
              n[0] = e1[1] * e2[2] - e1[2] * e2[1];
              n[1] = e1[2] * e2[0] - e1[0] * e2[2];
              n[2] = e1[0] * e2[1] - e1[1] * e2[0];
              // a repeated corner gets the sum more than once, as the block does
              for (int k = 0; k < 3; k++) begin
                acc_mem[ca][k] = clamp_add(acc_mem[ca][k], n[k]);
                acc_mem[cb][k] = clamp_add(acc_mem[cb][k], n[k]);
                acc_mem[cc][k] = clamp_add(acc_mem[cc][k], n[k]);
              end
            end
          end
          REQ_READ: normal_q.insert(normal_q.size(), vertex_normal(req.vertex_id));
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        normals_checked_o++;
        if (normal_q.size() == 0) begin
          report_mismatch($sformatf("unexpected normal for vertex %0d", rsp.out_vertex));
        end else begin
          automatic normal_t e = normal_q.pop_front();
          if (rsp.out_vertex !== e.vtx || rsp.norm_x !== e.nx || rsp.norm_y !== e.ny ||
              rsp.norm_z !== e.nz || rsp.status !== e.st)
            report_mismatch($sformatf(
              "vertex %0d got (%0d,%0d,%0d) st %0d, want %0d (%0d,%0d,%0d) st %0d",
              rsp.out_vertex, rsp.norm_x, rsp.norm_y, rsp.norm_z, rsp.status,
              e.vtx, e.nx, e.ny, e.nz, e.st));
        end
      end
    end
  end

  initial begin
    fail_count_o      = 0;
    normals_checked_o = 0;
  end

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import vna_pkg::*;

  // quiet cycles allowed before the run is declared hung; covers the
  // clearing sweep after reset and the slowest read
  localparam int unsigned HANG_LIMIT = 6000;
  localparam int unsigned DRAIN_CYCLES = 200;
  // request code the block ignores
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic             clk_i = 0;
  logic             rst_ni = 0;
  logic             cfg_we_i = 0;
  logic [CFG_W-1:0] cfg_wdata_i = 0;
  int unsigned      fail_count, normals_due, normals_checked;
  int unsigned      words_sent = 0;
  int unsigned      quiet_cycles = 0;
  bit               no_stall = 0;

  vna_req_if req ();
  vna_rsp_if rsp ();

  vertex_normal_accumulator_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req),
    .rsp_o       (rsp)
  );

  vna_normal_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .req               (req),
    .rsp               (rsp),
    .fail_count_o      (fail_count),
    .normals_due_o     (normals_due),
    .normals_checked_o (normals_checked)
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  initial begin
    req.valid = 0; req.req_type = 0; req.vertex_id = 0;
    req.pos_x = 0; req.pos_y = 0; req.pos_z = 0;
    req.corner_a = 0; req.corner_b = 0; req.corner_c = 0;
    rsp.ready = 0;
  end

  // Stall the receiver at random, about 11 percent of the time, except in the calm stretch.
  always @(posedge clk_i) rsp.ready <= no_stall || ($urandom_range(0, 99) >= 11);

  // Hang guard: count cycles where neither channel moves a word.
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Present one request word and hold it until it is taken. Ready only
  // moves after a rising edge, so sample it at the falling edge.
  task automatic send_word(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] vtx,
                           input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                           input logic [COORD_W-1:0] pz, input logic [IDX_W-1:0] ca,
                           input logic [IDX_W-1:0] cb, input logic [IDX_W-1:0] cc);
    bit took;
    took = 0;
    while (!no_stall && $urandom_range(0, 99) < 11) begin
      req.valid <= 0;
      @(posedge clk_i);
    end
    req.valid <= 1;
    req.req_type <= kind; req.vertex_id <= vtx;
    req.pos_x <= px; req.pos_y <= py; req.pos_z <= pz;
    req.corner_a <= ca; req.corner_b <= cb; req.corner_c <= cc;
    while (!took) begin
      @(negedge clk_i);
      took = req.ready;
      @(posedge clk_i);
    end
    words_sent++;
  endtask

  task automatic load_vertex(input logic [IDX_W-1:0] v, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
    send_word(REQ_LOAD, v, x, y, z, IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
  endtask

  task automatic add_triangle(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b,
                              input logic [IDX_W-1:0] c);
    send_word(REQ_TRI, IDX_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
              COORD_W'($urandom), a, b, c);
  endtask

  task automatic read_normal(input logic [IDX_W-1:0] v);
    send_word(REQ_READ, v, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
              IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
  endtask

  // Drain every pending normal, let the block finish, then write the threshold.
  task automatic set_threshold(input logic [CFG_W-1:0] value);
    req.valid <= 0;
    @(posedge clk_i);
    while (normals_due != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 0;
  endtask

  // Mostly a small working set so triangles land on loaded vertices.
  function automatic logic [IDX_W-1:0] pick_vertex();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return IDX_W'($urandom_range(0, 23));
    if (r < 93) return IDX_W'($urandom_range(1000, 1023));
    return IDX_W'($urandom);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(input int unsigned spread);
    case (spread)
      0: return COORD_W'($urandom_range(0, 16) - 8);
      1: return COORD_W'($urandom_range(0, 4095) - 2048);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [CFG_W-1:0] thresholds [5];
    int unsigned spread;
    thresholds = '{32'd0, 32'hFFFF_FFFF, 32'd65536, 32'd37, 32'h4000_0000};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    // threshold write lands during the clearing sweep
    cfg_we_i <= 1; cfg_wdata_i <= 32'd0;
    @(posedge clk_i);
    cfg_we_i <= 0;

    // Directed: extreme positions, every request kind, and the corner cases.
    read_normal(10'd1023);                         // never loaded
    load_vertex(10'd0, 16'sh7FFF, 16'sh8000, 16'sh0000);
    load_vertex(10'd1, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
    load_vertex(10'd2, 16'sh0000, 16'sh8000, 16'sh8000);
    read_normal(10'd0);                            // zero accumulator, degenerate
    add_triangle(10'd0, 10'd1, 10'd2);
    read_normal(10'd0);
    read_normal(10'd1);
    add_triangle(10'd2, 10'd1, 10'd0);             // opposite winding cancels
    read_normal(10'd2);
    load_vertex(10'd1023, 16'sh0100, 16'sh0000, 16'shFF00);
    add_triangle(10'd1023, 10'd1023, 10'd0);       // repeated corner adds zero
    add_triangle(10'd0, 10'd1, 10'd500);           // unloaded corner, ignored
    send_word(REQ_UNUSED, 10'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF, 10'h3FF, 10'h3FF);
    load_vertex(10'd3, 16'sh0001, 16'sh0000, 16'sh0000);
    load_vertex(10'd4, 16'sh0000, 16'sh0001, 16'sh0000);
    load_vertex(10'd5, 16'sh0000, 16'sh0000, 16'sh0001);
    add_triangle(10'd3, 10'd4, 10'd5);             // tiny area
    read_normal(10'd3);
    read_normal(10'd1023);
    load_vertex(10'd0, 16'sh0000, 16'sh0000, 16'sh0000); // reload clears sum
    read_normal(10'd0);

    // Random phases, one threshold each; the drain before each write also
    // holds the sender until every pending normal has arrived.
    foreach (thresholds[p]) begin
      set_threshold(thresholds[p]);
      spread = p % 3;
      for (int i = 0; i < 90; i++) begin
        int unsigned pick;
        no_stall = (p == 2 && i >= 20 && i < 70);
        pick = $urandom_range(0, 99);
        if (pick < 30)
          load_vertex(pick_vertex(), pick_coord(spread), pick_coord(spread),
                      pick_coord(spread));
        else if (pick < 75)
          add_triangle(pick_vertex(), pick_vertex(), pick_vertex());
        else if (pick < 96)
          read_normal(pick_vertex());
        else
          send_word(REQ_UNUSED, IDX_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                    COORD_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
                    IDX_W'($urandom));
        if ($urandom_range(0, 9) == 0) spread = $urandom_range(0, 2);
      end
      no_stall = 0;
    end

    req.valid <= 0;
    @(posedge clk_i);
    while (normals_due != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d request words over %0d thresholds, checked %0d normals",
             words_sent, $size(thresholds) + 1, normals_checked);
    if (fail_count == 0 && normals_due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d normals missing", fail_count, normals_due);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
hdl/vna_pkg.sv
hdl/vna_if.sv
hdl/vna_ram.sv
hdl/vna_mul.sv
hdl/vna_iter.sv
hdl/vertex_normal_accumulator_core.sv
verif/vna_normal_checker.sv
verif/tb.sv
